### sv/pcfc_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the pyro charge fire controller: command codes, register map, widths.
package pcfc_pkg;

  localparam int DUR_W    = 16;
  localparam int ADC_W    = 10;
  localparam int OP_W     = 3;
  localparam int STATE_W  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int CHK_W    = 10;

  // command codes
  localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
  localparam logic [OP_W-1:0] OP_ARM      = 3'd1;
  localparam logic [OP_W-1:0] OP_SAFE     = 3'd2;
  localparam logic [OP_W-1:0] OP_FIRE     = 3'd3;
  localparam logic [OP_W-1:0] OP_ESTOP    = 3'd4;
  localparam logic [OP_W-1:0] OP_POSITION = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FIRE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FIRE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REQ_CONT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_SHOT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONT_SENSE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CONT_THRESH = 3'd5;

  // register reset values
  localparam logic [DUR_W-1:0] MIN_FIRE_RST    = 16'd50;
  localparam logic [DUR_W-1:0] MAX_FIRE_RST    = 16'd1000;
  localparam logic [ADC_W-1:0] CONT_THRESH_RST = 10'd100;

  localparam logic [CHK_W-1:0] CHK_MAX = {CHK_W{1'b1}};
  localparam logic [DUR_W-1:0] DUR_MAX = {DUR_W{1'b1}};

endpackage

### sv/pyro_charge_fire_controller.sv
`timescale 1ns / 1ps
// Pyro charge fire controller: command register, combinational interlock step, result register.
//
// Each transfer on the input channel is one command (tick, arm, safe, fire, estop, set
// position) with a continuity ADC sample; each produces exactly one result with the accept
// flag, relay drive, charge state and latest continuity verdict. The block takes one command
// per clock while in_stall is low: a command is captured in the command register, the
// interlock state is updated by a single step of combinational logic when it leaves that
// register, and the result lands in the output register together with the new state.
// The step itself is the only loop (state register back to itself). Input stall rises only
// while both the command and the result register are full and out_stall holds the result
// back. Configuration writes are always taken (cfg_ready is 1) and must only be issued while
// no command is in flight.
module pyro_charge_fire_controller
  import pcfc_pkg::*;
#(
  parameter int CHECK_PERIOD_MS  = 1000,
  parameter int POSITION_FIRE_MS = 500
) (
  input  logic                 clk,
  input  logic                 rst,
  // command channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      operation,
  input  logic [DUR_W-1:0]     duration_ms,
  input  logic                 position_fire,
  input  logic [ADC_W-1:0]     continuity_reading,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 accepted,
  output logic                 relay_on,
  output logic [STATE_W-1:0]   charge_status,
  output logic                 continuity_good,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  typedef enum logic [STATE_W-1:0] {
    ST_SAFED  = 3'd0,
    ST_ARMED  = 3'd1,
    ST_FIRING = 3'd2,
    ST_FIRED  = 3'd3,
    ST_CFAIL  = 3'd4
  } charge_state_t;

  localparam logic [CHK_W-1:0] CHECK_LIMIT = CHK_W'(CHECK_PERIOD_MS);
  localparam logic [DUR_W-1:0] POS_DUR     = DUR_W'(POSITION_FIRE_MS);

  // configuration registers
  logic [DUR_W-1:0] min_fire_ms;
  logic [DUR_W-1:0] max_fire_ms;
  logic             require_continuity;
  logic             one_shot;
  logic             continuity_sensed;
  logic [ADC_W-1:0] continuity_threshold;

  // command register
  logic             cmd_valid;
  logic [OP_W-1:0]  cmd_op;
  logic [DUR_W-1:0] cmd_dur;
  logic             cmd_pos;
  logic [ADC_W-1:0] cmd_reading;

  // interlock state
  charge_state_t    charge_state, charge_state_next;
  logic             relay_drive, relay_drive_next;
  logic             last_continuity, last_continuity_next;
  logic [DUR_W-1:0] pulse_elapsed, pulse_elapsed_next;
  logic [DUR_W-1:0] pulse_length, pulse_length_next;
  logic [CHK_W-1:0] check_count, check_count_next;
  logic             ok_next;

  logic             advance;
  logic             step;
  logic             cont_ok;
  logic             fire_req;
  logic [DUR_W-1:0] fire_dur;
  logic [CHK_W-1:0] check_inc;
  logic [DUR_W-1:0] elapsed_inc;

  assign advance   = !out_valid || !out_stall;
  assign step      = cmd_valid && advance;
  assign in_stall  = cmd_valid && !advance;
  assign cfg_ready = 1'b1;

  assign cont_ok  = !continuity_sensed || (cmd_reading > continuity_threshold);
  assign fire_req = (cmd_op == OP_FIRE) || ((cmd_op == OP_POSITION) && cmd_pos);
  assign fire_dur = (cmd_op == OP_POSITION) ? POS_DUR : cmd_dur;
  assign check_inc   = (check_count != CHK_MAX) ? check_count + 1'b1 : check_count;
  assign elapsed_inc = (pulse_elapsed != DUR_MAX) ? pulse_elapsed + 1'b1 : pulse_elapsed;

  always_comb begin
    charge_state_next    = charge_state;
    relay_drive_next     = relay_drive;
    last_continuity_next = last_continuity;
    pulse_elapsed_next   = pulse_elapsed;
    pulse_length_next    = pulse_length;
    check_count_next     = check_count;
    ok_next              = 1'b0;
    if (fire_req) begin
      if ((charge_state == ST_ARMED) && (fire_dur >= min_fire_ms) &&
          (fire_dur <= max_fire_ms)) begin
        if (require_continuity) begin
          last_continuity_next = cont_ok;
        end
        if (require_continuity && !cont_ok) begin
          charge_state_next = ST_CFAIL;
        end else begin
          charge_state_next  = ST_FIRING;
          pulse_length_next  = fire_dur;
          pulse_elapsed_next = '0;
          relay_drive_next   = 1'b1;
          ok_next            = 1'b1;
        end
      end
    end else begin
      case (cmd_op)
        OP_TICK: begin
          ok_next          = 1'b1;
          check_count_next = check_inc;
          if (charge_state == ST_FIRING) begin
            pulse_elapsed_next = elapsed_inc;
            if (elapsed_inc >= pulse_length) begin
              relay_drive_next  = 1'b0;
              charge_state_next = ST_FIRED;
            end
          end
          // periodic continuity check while armed
          if ((charge_state == ST_ARMED) && (check_inc > CHECK_LIMIT)) begin
            last_continuity_next = cont_ok;
            check_count_next     = '0;
          end
        end
        OP_ARM: begin
          if ((charge_state != ST_FIRING) && !(one_shot && (charge_state == ST_FIRED))) begin
            if (require_continuity) begin
              last_continuity_next = cont_ok;
            end
            if (require_continuity && !cont_ok) begin
              charge_state_next = ST_CFAIL;
            end else begin
              charge_state_next = ST_ARMED;
              ok_next           = 1'b1;
            end
          end
        end
        OP_SAFE, OP_ESTOP, OP_POSITION: begin
          // set position with 0 lands here as a safe command
          ok_next          = 1'b1;
          relay_drive_next = 1'b0;
          if (charge_state != ST_FIRED) begin
            charge_state_next = ST_SAFED;
          end
        end
        default: begin
          ok_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_fire_ms          <= MIN_FIRE_RST;
      max_fire_ms          <= MAX_FIRE_RST;
      require_continuity   <= 1'b1;
      one_shot             <= 1'b1;
      continuity_sensed    <= 1'b0;
      continuity_threshold <= CONT_THRESH_RST;
      cmd_valid            <= 1'b0;
      out_valid            <= 1'b0;
      charge_state         <= ST_SAFED;
      relay_drive          <= 1'b0;
      last_continuity      <= 1'b0;
      pulse_elapsed        <= '0;
      pulse_length         <= '0;
      check_count          <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_FIRE:    min_fire_ms          <= cfg_data;
          REG_MAX_FIRE:    max_fire_ms          <= cfg_data;
          REG_REQ_CONT:    require_continuity   <= cfg_data[0];
          REG_ONE_SHOT:    one_shot             <= cfg_data[0];
          REG_CONT_SENSE:  continuity_sensed    <= cfg_data[0];
          REG_CONT_THRESH: continuity_threshold <= cfg_data[ADC_W-1:0];
          default: begin
          end
        endcase
      end
      // command register refills whenever it is empty or being drained
      if (!in_stall) begin
        cmd_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= cmd_valid;
      end
      if (step) begin
        charge_state    <= charge_state_next;
        relay_drive     <= relay_drive_next;
        last_continuity <= last_continuity_next;
        pulse_elapsed   <= pulse_elapsed_next;
        pulse_length    <= pulse_length_next;
        check_count     <= check_count_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      cmd_op      <= operation;
      cmd_dur     <= duration_ms;
      cmd_pos     <= position_fire;
      cmd_reading <= continuity_reading;
    end
    if (step) begin
      accepted        <= ok_next;
      relay_on        <= relay_drive_next;
      charge_status   <= charge_state_next;
      continuity_good <= last_continuity_next;
    end
  end

  // relay is driven exactly while the charge is firing
  a_relay_firing: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (relay_on == (charge_status == ST_FIRING)))
    else $error("relay drive and firing state disagree");

  // the relay only comes on from a fire or set-position command
  a_relay_source: assert property (@(posedge clk) disable iff (rst)
    (!relay_drive ##1 relay_drive) |->
      $past(step && ((cmd_op == OP_FIRE) || (cmd_op == OP_POSITION))))
    else $error("relay turned on without a fire command");

  // input backpressure only when a result is held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with the result side free");

endmodule

### test/tb_pyro_charge_fire_controller.sv
`timescale 1ns / 1ps
// Self-checking testbench for the pyro charge fire controller: directed and random commands.
module tb_pyro_charge_fire_controller;
  import pcfc_pkg::*;

  localparam int CHECK_PERIOD_MS  = 1000;
  localparam int POSITION_FIRE_MS = 500;
  localparam int LONG_HOLD        = 400;
  localparam int QUIET_LIMIT      = 3000;
  localparam int RANDOM_ITEMS     = 240;

  // command codes the block ignores
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;
  // register indexes past the end of the map
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef enum logic [STATE_W-1:0] {
    CHG_SAFED     = 3'd0,
    CHG_ARMED     = 3'd1,
    CHG_FIRING    = 3'd2,
    CHG_FIRED     = 3'd3,
    CHG_CONT_FAIL = 3'd4
  } charge_state_e;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [DUR_W-1:0] dur;
    logic             pos;
    logic [ADC_W-1:0] reading;
  } command_t;

  typedef struct packed {
    logic          ok;
    logic          relay;
    charge_state_e state;
    logic          cont;
  } report_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      operation = OP_TICK;
  logic [DUR_W-1:0]     duration_ms = '0;
  logic                 position_fire = 1'b0;
  logic [ADC_W-1:0]     continuity_reading = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 accepted;
  logic                 relay_on;
  logic [STATE_W-1:0]   charge_status;
  logic                 continuity_good;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  always #6 clk = ~clk;

  pyro_charge_fire_controller #(
    .CHECK_PERIOD_MS (CHECK_PERIOD_MS),
    .POSITION_FIRE_MS(POSITION_FIRE_MS)
  ) uut (.*);

  // interlock state as predicted, starting from reset values
  charge_state_e    charge = CHG_SAFED;
  logic             relay = 1'b0;
  logic             last_cont = 1'b0;
  logic [DUR_W-1:0] pulse_count = '0;
  logic [DUR_W-1:0] pulse_len = '0;
  logic [CHK_W-1:0] check_count = '0;
  logic [DUR_W-1:0] fire_min = MIN_FIRE_RST;
  logic [DUR_W-1:0] fire_max = MAX_FIRE_RST;
  logic             need_cont = 1'b1;
  logic             one_shot_mode = 1'b1;
  logic             cont_sensed = 1'b0;
  logic [ADC_W-1:0] cont_thresh = CONT_THRESH_RST;

  report_t pending_reports[$];
  report_t want_report;
  int      fault_count = 0;
  int      result_index = 0;
  int      sent_items = 0;
  int      burst_left = 0;
  bit      gap_enable = 1'b0;
  bit      stall_enable = 1'b0;
  int      hold_requests = 0;
  int      hold_served = 0;
  int      hold_left = 0;
  logic [15:0] stall_pattern = '0;
  logic [4:0]  pattern_pos = '0;
  int      quiet_cycles = 0;

  function automatic logic sense_line(logic [ADC_W-1:0] reading);
    last_cont = !cont_sensed || (reading > cont_thresh);
    return last_cont;
  endfunction

  function automatic void drop_relay();
    relay = 1'b0;
    if (charge != CHG_FIRED) charge = CHG_SAFED;
  endfunction

  function automatic logic start_pulse(logic [DUR_W-1:0] dur, logic [ADC_W-1:0] reading);
    if (charge != CHG_ARMED) return 1'b0;
    if (dur < fire_min || dur > fire_max) return 1'b0;
    if (need_cont) begin
      if (!sense_line(reading)) begin
        charge = CHG_CONT_FAIL;
        return 1'b0;
      end
    end
    charge = CHG_FIRING;
    pulse_len = dur;
    pulse_count = '0;
    relay = 1'b1;
    return 1'b1;
  endfunction

  function automatic report_t interlock_step(command_t c);
    report_t r;
    logic ok;
    ok = 1'b0;
    case (c.op)
      OP_TICK: begin
        if (check_count != CHK_MAX) check_count = check_count + 1'b1;
        if (charge == CHG_FIRING) begin
          if (pulse_count != DUR_MAX) pulse_count = pulse_count + 1'b1;
          if (pulse_count >= pulse_len) begin
            relay = 1'b0;
            charge = CHG_FIRED;
          end
        end
        if (charge == CHG_ARMED && check_count > CHECK_PERIOD_MS) begin
          void'(sense_line(c.reading));
          check_count = '0;
        end
        ok = 1'b1;
      end
      OP_ARM: begin
        if (charge == CHG_FIRING || (one_shot_mode && charge == CHG_FIRED)) begin
          ok = 1'b0;
        end else if (need_cont && !sense_line(c.reading)) begin
          charge = CHG_CONT_FAIL;
        end else begin
          charge = CHG_ARMED;
          ok = 1'b1;
        end
      end
      OP_SAFE, OP_ESTOP: begin
        drop_relay();
        ok = 1'b1;
      end
      OP_FIRE: ok = start_pulse(c.dur, c.reading);
      OP_POSITION: begin
        if (c.pos) begin
          ok = start_pulse(DUR_W'(POSITION_FIRE_MS), c.reading);
        end else begin
          drop_relay();
          ok = 1'b1;
        end
      end
      default: ok = 1'b0;
    endcase
    r.ok = ok;
    r.relay = relay;
    r.state = charge;
    r.cont = last_cont;
    return r;
  endfunction

  function automatic command_t cmd(logic [OP_W-1:0] op, int dur, int pos, int reading);
    command_t c;
    c.op = op;
    c.dur = dur[DUR_W-1:0];
    c.pos = pos[0];
    c.reading = reading[ADC_W-1:0];
    return c;
  endfunction

  function automatic command_t random_command();
    return cmd(OP_W'($urandom_range(0, 7)), $urandom_range(0, 65535), $urandom_range(0, 1),
               $urandom_range(0, 1023));
  endfunction

  // mostly inside the pulse limits, sometimes one past either edge
  function automatic int pick_duration();
    int lo, hi;
    lo = fire_min;
    hi = fire_max;
    if (lo > hi || $urandom_range(0, 7) == 0) return $urandom_range(0, 65535);
    if ($urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 1) && lo > 0) return lo - 1;
      return (hi < 65535) ? hi + 1 : hi;
    end
    return lo + $urandom_range(0, (hi - lo > 10) ? 10 : hi - lo);
  endfunction

  // half the readings sit within one of the threshold
  function automatic int pick_reading();
    int t;
    if ($urandom_range(0, 1)) return $urandom_range(0, 1023);
    t = int'(cont_thresh) + int'($urandom_range(0, 2)) - 1;
    if (t < 0) t = 0;
    if (t > 1023) t = 1023;
    return t;
  endfunction

  task automatic send_cmd(command_t c);
    in_valid <= 1'b1;
    operation <= c.op;
    duration_ms <= c.dur;
    position_fire <= c.pos;
    continuity_reading <= c.reading;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_reports.push_back(interlock_step(c));
    if (c.op <= OP_POSITION) sent_items++;
    if (gap_enable) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MIN_FIRE:    fire_min = data;
      REG_MAX_FIRE:    fire_max = data;
      REG_REQ_CONT:    need_cont = data[0];
      REG_ONE_SHOT:    one_shot_mode = data[0];
      REG_CONT_SENSE:  cont_sensed = data[0];
      REG_CONT_THRESH: cont_thresh = data[ADC_W-1:0];
      default: ;
    endcase
  endtask

  // unused upper bits carry noise; the block must mask them
  task automatic load_settings(int lo, int hi, int req, int one, int sensed, int thresh);
    logic [15:0] noise;
    settle();
    noise = 16'($urandom);
    write_reg(REG_MIN_FIRE, lo[15:0]);
    write_reg(REG_MAX_FIRE, hi[15:0]);
    write_reg(REG_REQ_CONT, {noise[15:1], req[0]});
    noise = 16'($urandom);
    write_reg(REG_ONE_SHOT, {noise[15:1], one[0]});
    noise = 16'($urandom);
    write_reg(REG_CONT_SENSE, {noise[15:1], sensed[0]});
    noise = 16'($urandom);
    write_reg(REG_CONT_THRESH, {noise[15:10], thresh[9:0]});
    if ($urandom_range(0, 1)) write_reg(REG_SPARE_A, 16'($urandom));
    if ($urandom_range(0, 1)) write_reg(REG_SPARE_B, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // arm, fire, tick through part or all of the pulse, then maybe back to safe
  task automatic run_sequence();
    int ticks;
    ticks = $urandom_range(0, 14);
    send_cmd(cmd(OP_ARM, $urandom_range(0, 65535), $urandom_range(0, 1), pick_reading()));
    if ($urandom_range(0, 3) == 0)
      send_cmd(cmd(OP_POSITION, $urandom_range(0, 65535), 1, pick_reading()));
    else
      send_cmd(cmd(OP_FIRE, pick_duration(), $urandom_range(0, 1), pick_reading()));
    repeat (ticks)
      send_cmd(cmd(OP_TICK, $urandom_range(0, 65535), $urandom_range(0, 1), pick_reading()));
    case ($urandom_range(0, 3))
      0: send_cmd(cmd(OP_SAFE, $urandom_range(0, 65535), 1, pick_reading()));
      1: send_cmd(cmd(OP_ESTOP, $urandom_range(0, 65535), 1, pick_reading()));
      2: send_cmd(cmd(OP_POSITION, $urandom_range(0, 65535), 0, pick_reading()));
      default: ;
    endcase
  endtask

  task automatic test_reset_config();
    gap_enable = 1'b0;
    stall_enable = 1'b0;
    send_cmd(cmd(OP_FIRE, 100, 0, 0));
    send_cmd(cmd(OP_ARM, 0, 0, 0));
    send_cmd(cmd(OP_ARM, 0, 0, 5));
    send_cmd(cmd(OP_FIRE, 49, 0, 0));
    send_cmd(cmd(OP_FIRE, 1001, 0, 0));
    send_cmd(cmd(OP_SPARE_A, 0, 0, 0));
    send_cmd(cmd(OP_SPARE_B, 65535, 1, 1023));
    send_cmd(cmd(OP_POSITION, 0, 0, 0));
    send_cmd(cmd(OP_TICK, 0, 0, 0));
  endtask

  task automatic test_continuity_one_shot();
    load_settings(0, 3, 1, 1, 1, 100);
    send_cmd(cmd(OP_ARM, 0, 0, 100));
    send_cmd(cmd(OP_ARM, 0, 0, 101));
    send_cmd(cmd(OP_FIRE, 0, 0, 1023));
    send_cmd(cmd(OP_ARM, 0, 0, 1023));
    send_cmd(cmd(OP_TICK, 0, 0, 0));
    send_cmd(cmd(OP_ARM, 0, 0, 1023));
    send_cmd(cmd(OP_SAFE, 0, 0, 0));
    send_cmd(cmd(OP_ESTOP, 0, 0, 0));
    send_cmd(cmd(OP_FIRE, 2, 0, 1023));
  endtask

  task automatic test_pulse_limits();
    load_settings(0, 65535, 1, 0, 1, 0);
    send_cmd(cmd(OP_ARM, 0, 0, 1));
    send_cmd(cmd(OP_FIRE, 65535, 0, 1));
    send_cmd(cmd(OP_ESTOP, 0, 0, 0));
    send_cmd(cmd(OP_ARM, 0, 0, 1));
    send_cmd(cmd(OP_POSITION, 0, 1, 1));
    send_cmd(cmd(OP_TICK, 0, 0, 0));
    send_cmd(cmd(OP_SAFE, 0, 0, 0));
    send_cmd(cmd(OP_ARM, 0, 0, 0));
    send_cmd(cmd(OP_FIRE, 5, 0, 1));
    // min above max refuses every fire; no continuity needed for arm
    load_settings(10, 5, 0, 0, 1, 1023);
    send_cmd(cmd(OP_ARM, 0, 0, 0));
    send_cmd(cmd(OP_FIRE, 7, 0, 0));
    send_cmd(cmd(OP_POSITION, 0, 1, 0));
    send_cmd(cmd(OP_FIRE, 10, 0, 0));
  endtask

  // saturate the interval counter while safe, then arm: one check at once, the next a
  // full period later
  task automatic test_periodic_check();
    load_settings(1, 20, 1, 0, 1, 300);
    gap_enable = 1'b1;
    stall_enable = 1'b1;
    send_cmd(cmd(OP_SAFE, 0, 0, 0));
    repeat (1025) send_cmd(cmd(OP_TICK, 0, 0, $urandom_range(0, 1023)));
    send_cmd(cmd(OP_ARM, 0, 0, 1023));
    repeat (1002) send_cmd(cmd(OP_TICK, $urandom_range(0, 65535), 0, pick_reading()));
  endtask

  // results held off for a long stretch while commands keep coming
  task automatic test_backpressure();
    load_settings(0, 6, 1, 0, 1, 200);
    gap_enable = 1'b0;
    stall_enable = 1'b0;
    hold_requests++;
    repeat (20) begin
      if ($urandom_range(0, 2) == 0) send_cmd(random_command());
      else run_sequence();
    end
    settle();
  endtask

  task automatic test_random_phases();
    int goal;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: load_settings(0, 8, 1, 0, 1, $urandom_range(0, 1023));
        1: load_settings(2, 6, 1, 1, 1, 0);
        2: load_settings(0, 65535, 1, 0, 1, 1023);
        3: load_settings(1, 10, 0, 0, 1, $urandom_range(0, 1023));
        4: load_settings(7, 3, 1, 0, 0, $urandom_range(0, 1023));
        5: load_settings(5, 5, 1, 0, 1, $urandom_range(0, 1023));
        6: load_settings(0, 12, 1, 1, 0, 100);
        default: load_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
                               $urandom_range(0, 1), $urandom_range(0, 1),
                               $urandom_range(0, 1), $urandom_range(0, 1023));
      endcase
      gap_enable = phase[0];
      stall_enable = phase[1] | phase[2];
      goal = sent_items + RANDOM_ITEMS / 8;
      while (sent_items < goal) begin
        if ($urandom_range(0, 9) < 7) run_sequence();
        else send_cmd(random_command());
      end
    end
  endtask

  // result side: long hold-off on request, otherwise a rotating stall pattern
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (!stall_enable) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= stall_pattern[0];
      if (pattern_pos == '0) stall_pattern <= 16'($urandom & $urandom);
      else stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
      pattern_pos <= pattern_pos + 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      result_index++;
      if (pending_reports.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("result %0d unexpected: ok/relay/state/cont %0d/%0d/%0d/%0d",
                   result_index, accepted, relay_on, charge_status, continuity_good);
      end else begin
        want_report = pending_reports.pop_front();
        if (accepted !== want_report.ok || relay_on !== want_report.relay ||
            charge_status !== want_report.state || continuity_good !== want_report.cont) begin
          fault_count++;
          if (fault_count <= 10)
            $display("result %0d: ok/relay/state/cont want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     result_index, want_report.ok, want_report.relay, want_report.state,
                     want_report.cont, accepted, relay_on, charge_status, continuity_good);
        end
      end
    end
  end

  // any transfer on any channel counts as progress
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_pyro_charge_fire_controller: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_reset_config();
    test_continuity_one_shot();
    test_pulse_limits();
    test_periodic_check();
    test_backpressure();
    test_random_phases();
    settle();
    repeat (4) @(posedge clk);
    if (fault_count == 0 && pending_reports.size() == 0) begin
      $display("tb_pyro_charge_fire_controller: clean");
    end else begin
      $display("tb_pyro_charge_fire_controller: errors");
    end
    $finish;
  end

endmodule

### pyro_charge_fire_controller.f
sv/pcfc_pkg.sv
sv/pyro_charge_fire_controller.sv
test/tb_pyro_charge_fire_controller.sv
